/* src/http_chunked_body_decoder_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define HCBD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hcbd_pkg.sv */
// ---------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder.
// ---------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [4:0] {
        PH_SIZE    = 5'b00001,
        PH_SKIP    = 5'b00010,
        PH_DATA    = 5'b00100,
        PH_END     = 5'b01000,
        PH_TRAILER = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_hex;
        logic [3:0] hex_val;
    } cls_t;

    typedef struct packed {
        logic not_empty;
        cls_t item;
    } q_head_t;

endpackage

/* src/hcbd_front.sv */
// ---------------------------------------------------------------------------
// hcbd_front
// Classify each incoming byte: line-end characters, space, hex digit value.
// ---------------------------------------------------------------------------
module hcbd_front (
    input  logic [7:0]    in_byte,
    output hcbd_pkg::cls_t cls
);

    logic       dig;
    logic       low;
    logic       upp;
    logic [7:0] dig_v;
    logic [7:0] low_v;
    logic [7:0] upp_v;

    always_comb begin
        dig   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        low   = (in_byte >= 8'h61) && (in_byte <= 8'h66);
        upp   = (in_byte >= 8'h41) && (in_byte <= 8'h46);
        dig_v = in_byte - 8'h30;
        low_v = in_byte - 8'h57;
        upp_v = in_byte - 8'h37;

        cls.data    = in_byte;
        cls.is_cr   = (in_byte == hcbd_pkg::CHAR_CR);
        cls.is_lf   = (in_byte == hcbd_pkg::CHAR_LF);
        cls.is_sp   = (in_byte == hcbd_pkg::CHAR_SPACE);
        cls.is_hex  = dig || low || upp;
        if (dig) begin
            cls.hex_val = dig_v[3:0];
        end else if (low) begin
            cls.hex_val = low_v[3:0];
        end else if (upp) begin
            cls.hex_val = upp_v[3:0];
        end else begin
            cls.hex_val = 4'd0;
        end
    end

endmodule

/* src/hcbd_queue.sv */
// ---------------------------------------------------------------------------
// hcbd_queue
// Short FIFO of classified bytes between the front and the back.
// ---------------------------------------------------------------------------
module hcbd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hcbd_pkg::cls_t    push_item,
    output logic              full,
    input  logic              pop,
    output hcbd_pkg::q_head_t head
);

    hcbd_pkg::cls_t                entry_reg [hcbd_pkg::QUEUE_DEPTH];
    logic [hcbd_pkg::QAW-1:0]      wr_ptr_reg;
    logic [hcbd_pkg::QAW-1:0]      wr_ptr_next;
    logic [hcbd_pkg::QAW-1:0]      rd_ptr_reg;
    logic [hcbd_pkg::QAW-1:0]      rd_ptr_next;
    logic [hcbd_pkg::QAW:0]        count_reg;
    logic [hcbd_pkg::QAW:0]        count_next;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        full           = (count_reg == (hcbd_pkg::QAW+1)'(hcbd_pkg::QUEUE_DEPTH));
        head.not_empty = (count_reg != '0);
        head.item      = entry_reg[rd_ptr_reg];
        do_push        = push && !full;
        do_pop         = pop && head.not_empty;
        wr_ptr_next    = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next    = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next     = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/hcbd_back.sv */
// ---------------------------------------------------------------------------
// hcbd_back
// Chunk framing state machine and output register.
// ---------------------------------------------------------------------------
module hcbd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  hcbd_pkg::q_head_t head,
    output logic              pop,
    output logic [7:0]        out_byte,
    output logic [1:0]        out_kind,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int SB = hcbd_pkg::SIZE_BITS;

    hcbd_pkg::phase_t phase_reg;
    hcbd_pkg::phase_t phase_next;
    logic [SB-1:0]    rem_reg;
    logic [SB-1:0]    rem_next;
    logic             lhc_reg;
    logic             lhc_next;
    logic             sde_reg;
    logic             sde_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic [1:0]       out_kind_reg;
    logic [1:0]       out_kind_next;

    hcbd_pkg::phase_t eff_phase;
    logic [SB-1:0]    eff_rem;
    logic             eff_lhc;
    logic             eff_sde;
    logic [SB-1:0]    rem_dec;
    logic             emit;
    logic [7:0]       emit_byte;
    logic [1:0]       emit_kind;
    hcbd_pkg::cls_t   c;

    always_comb begin
        c   = head.item;
        pop = head.not_empty && (!out_valid_reg || out_ready);

        case (phase_reg)
            hcbd_pkg::PH_SIZE, hcbd_pkg::PH_SKIP, hcbd_pkg::PH_DATA,
            hcbd_pkg::PH_END, hcbd_pkg::PH_TRAILER: begin
                eff_phase = phase_reg;
                eff_rem   = rem_reg;
                eff_lhc   = lhc_reg;
                eff_sde   = sde_reg;
            end
            default: begin
                eff_phase = hcbd_pkg::PH_SIZE;
                eff_rem   = '0;
                eff_lhc   = 1'b0;
                eff_sde   = 1'b0;
            end
        endcase

        rem_dec    = (eff_rem != '0) ? eff_rem - SB'(1) : eff_rem;
        phase_next = eff_phase;
        rem_next   = eff_rem;
        lhc_next   = eff_lhc;
        sde_next   = eff_sde;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        emit_kind  = hcbd_pkg::KIND_DATA;

        if (eff_phase == hcbd_pkg::PH_DATA) begin
            rem_next  = rem_dec;
            if (rem_dec == '0) begin
                phase_next = hcbd_pkg::PH_END;
            end
            emit      = 1'b1;
            emit_byte = c.data;
        end else if (c.is_cr) begin
            phase_next = eff_phase;
        end else if (c.is_lf) begin
            lhc_next = 1'b0;
            sde_next = 1'b0;
            if (eff_phase == hcbd_pkg::PH_SIZE) begin
                phase_next = (eff_rem == '0) ? hcbd_pkg::PH_TRAILER : hcbd_pkg::PH_DATA;
            end else if (eff_phase == hcbd_pkg::PH_TRAILER && !eff_lhc) begin
                phase_next = hcbd_pkg::PH_SIZE;
                rem_next   = '0;
                emit       = 1'b1;
                emit_kind  = hcbd_pkg::KIND_DONE;
            end else if (eff_phase != hcbd_pkg::PH_TRAILER) begin
                phase_next = hcbd_pkg::PH_SIZE;
                rem_next   = '0;
            end
        end else if (c.is_sp && !eff_lhc) begin
            phase_next = eff_phase;
        end else begin
            lhc_next = 1'b1;
            if (eff_phase == hcbd_pkg::PH_SIZE && !eff_sde) begin
                if (!c.is_hex) begin
                    sde_next = 1'b1;
                end else if (eff_rem[SB-1 -: 4] != 4'd0) begin
                    phase_next = hcbd_pkg::PH_SKIP;
                    rem_next   = '0;
                    emit       = 1'b1;
                    emit_kind  = hcbd_pkg::KIND_ERROR;
                end else begin
                    rem_next = {eff_rem[SB-5:0], c.hex_val};
                end
            end
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        if (pop && emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_kind_next  = emit_kind;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= hcbd_pkg::PH_SIZE;
            rem_reg       <= '0;
            lhc_reg       <= 1'b0;
            sde_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                lhc_reg   <= lhc_next;
                sde_reg   <= sde_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_kind  = out_kind_reg;

endmodule

/* src/http_chunked_body_decoder_top.sv */
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_top
// HTTP/1.1 chunked body decoder: byte classifier, short queue, framing
// state machine with a registered result.
//
//   channel   dir   tdata                       tuser
//   s_        in    [7:0] stream_byte           -
//   m_        out   [7:0] out_byte              [1:0] out_kind
//
// One byte per cycle sustained unless the output stalls; a result passes
// a queue entry and then the output register. The framing state machine
// updates once per dequeued byte, which sets the rate; a four-entry queue
// lets input and output stall independently. Reset is synchronous and
// clears all control state. s_tready drops only while the queue is full.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser    // [1:0] out_kind
);

    hcbd_pkg::cls_t    cls;
    hcbd_pkg::q_head_t head;
    logic              q_full;
    logic              pop;

    hcbd_front u_front (
        .in_byte (s_tdata),
        .cls     (cls)
    );

    hcbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (cls),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    hcbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_byte  (m_tdata),
        .out_kind  (m_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign s_tready = !q_full;

endmodule

/* src/hcbd_checker.sv */
// ---------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "http_chunked_body_decoder_top_defines.svh"

module hcbd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    `HCBD_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "input transaction dropped or changed while stalled")
    `HCBD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped or changed while stalled")
    `HCBD_ASSERT_IMPLY(a_ctrl_zero, aclk, aresetn, m_tvalid && (m_tuser != hcbd_pkg::KIND_DATA), m_tdata == 8'd0, "nonzero data on a status result")
    `HCBD_ASSERT_IMPLY(a_kind_legal, aclk, aresetn, m_tvalid, (m_tuser == hcbd_pkg::KIND_DATA) || (m_tuser == hcbd_pkg::KIND_DONE) || (m_tuser == hcbd_pkg::KIND_ERROR), "illegal result kind")
    `HCBD_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid && s_tready, "outputs active after reset")

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
